[design/mlcc_pkg.sv]
// ----------------------------------------------------------------------------
// mlcc_pkg
// Shared types, register map and reset values for the motion light and
// camera controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mlcc_pkg;

  localparam int LevelW     = 16;
  localparam int CfgW       = 16;
  localparam int LightW     = 3;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 5;
  localparam int CountWidth = 16;

  // light bit positions
  localparam int LightPorch    = 0;
  localparam int LightFoyer    = 1;
  localparam int LightSecurity = 2;

  typedef enum logic [2:0] {
    REG_MANUAL_ON     = 3'd0,
    REG_AUTO_ENABLE   = 3'd1,
    REG_DARK_THRESH   = 3'd2,
    REG_FOYER_HOLD    = 3'd3,
    REG_SECURITY_HOLD = 3'd4,
    REG_PULSE_LENGTH  = 3'd5,
    REG_COOLDOWN      = 3'd6
  } reg_idx_e;

  localparam logic [LightW-1:0] RstManualOn   = 3'd0;
  localparam logic [LightW-1:0] RstAutoEnable = 3'd7;
  localparam logic [CfgW-1:0]   RstDarkThresh = 16'd120;
  localparam logic [CfgW-1:0]   RstFoyerHold  = 16'd200;
  localparam logic [CfgW-1:0]   RstSecHold    = 16'd200;
  localparam logic [CfgW-1:0]   RstPulseLen   = 16'd3;
  localparam logic [CfgW-1:0]   RstCooldown   = 16'd30;

  typedef struct packed {
    logic [LightW-1:0] manual_on;
    logic [LightW-1:0] auto_enable;
    logic [CfgW-1:0]   dark_limit;
    logic [CfgW-1:0]   foyer_hold;
    logic [CfgW-1:0]   security_hold;
    logic [CfgW-1:0]   pulse_length;
    logic [CfgW-1:0]   trigger_cooldown;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] ambient_level;
    logic              ambient_valid;
    logic              motion_outside;
    logic              motion_inside;
  } in_t;

  typedef struct packed {
    logic              porch_light;
    logic              foyer_light;
    logic              security_light;
    logic              camera_trigger;
    logic              is_dark;
    logic [LightW-1:0] light_change_mask;
  } res_t;

endpackage

`default_nettype wire

[design/mlcc_in_if.sv]
// ----------------------------------------------------------------------------
// mlcc_in_if
// Sensor word channel: valid/ready handshake with one tick's samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlcc_in_if;
  import mlcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] ambient_level;
  logic              ambient_valid;
  logic              motion_outside;
  logic              motion_inside;

  modport source (
    output valid, ambient_level, ambient_valid, motion_outside, motion_inside,
    input  ready
  );

  modport sink (
    input  valid, ambient_level, ambient_valid, motion_outside, motion_inside,
    output ready
  );
endinterface

`default_nettype wire

[design/mlcc_out_if.sv]
// ----------------------------------------------------------------------------
// mlcc_out_if
// Result word channel: valid/ready handshake with light and camera drives.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlcc_out_if;
  import mlcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              porch_light;
  logic              foyer_light;
  logic              security_light;
  logic              camera_trigger;
  logic              is_dark;
  logic [LightW-1:0] light_change_mask;

  modport source (
    output valid, porch_light, foyer_light, security_light, camera_trigger,
           is_dark, light_change_mask,
    input  ready
  );

  modport sink (
    input  valid, porch_light, foyer_light, security_light, camera_trigger,
           is_dark, light_change_mask,
    output ready
  );
endinterface

`default_nettype wire

[design/motion_light_and_camera_controller_top.sv]
// ----------------------------------------------------------------------------
// motion_light_and_camera_controller_top
// Porch, foyer and security light control with a camera trigger pulse.
// ----------------------------------------------------------------------------
// Each sensor word on in_i is one control tick and yields exactly one result
// word on out_o. A word is captured in an input register, evaluated by the
// tick logic and written to a result register, and one word per cycle is
// taken sustained as long as out_o drains. Hold, pulse and cooldown timing
// is counted in accepted words by saturating COUNT_WIDTH-bit counters; the
// hold and cooldown counters start saturated, so after reset no light is
// held and no cooldown is pending. Settings must be written over APB only
// while no word is in flight; the block itself does not enforce this.
`default_nettype none

module motion_light_and_camera_controller_top #(
  parameter int COUNT_WIDTH = mlcc_pkg::CountWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mlcc_in_if.sink                            in_i,
  mlcc_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlcc_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [mlcc_pkg::ApbDataW-1:0] pwdata,
  output logic      [mlcc_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import mlcc_pkg::*;

  cfg_t cfg;
  in_t  item_q;
  res_t res, res_q;
  logic item_vld_q, res_vld_q;
  logic advance, in_fire;

  mlcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // word moves from input register to result register
  assign advance     = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !item_vld_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) item_vld_q <= in_i.valid;
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.ambient_level  <= in_i.ambient_level;
      item_q.ambient_valid  <= in_i.ambient_valid;
      item_q.motion_outside <= in_i.motion_outside;
      item_q.motion_inside  <= in_i.motion_inside;
    end
    if (advance) res_q <= res;
  end

  mlcc_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (item_q),
    .res_o     (res)
  );

  assign out_o.valid             = res_vld_q;
  assign out_o.porch_light       = res_q.porch_light;
  assign out_o.foyer_light       = res_q.foyer_light;
  assign out_o.security_light    = res_q.security_light;
  assign out_o.camera_trigger    = res_q.camera_trigger;
  assign out_o.is_dark           = res_q.is_dark;
  assign out_o.light_change_mask = res_q.light_change_mask;

endmodule

`default_nettype wire

[design/mlcc_cfg.sv]
// ----------------------------------------------------------------------------
// mlcc_cfg
// APB register file holding the controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcc_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlcc_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [mlcc_pkg::ApbDataW-1:0]   pwdata,
  output logic      [mlcc_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready,
  output mlcc_pkg::cfg_t                       cfg_o
);
  import mlcc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MANUAL_ON:     cfg_d.manual_on        = pwdata[LightW-1:0];
        REG_AUTO_ENABLE:   cfg_d.auto_enable      = pwdata[LightW-1:0];
        REG_DARK_THRESH:   cfg_d.dark_limit       = pwdata[CfgW-1:0];
        REG_FOYER_HOLD:    cfg_d.foyer_hold       = pwdata[CfgW-1:0];
        REG_SECURITY_HOLD: cfg_d.security_hold    = pwdata[CfgW-1:0];
        REG_PULSE_LENGTH:  cfg_d.pulse_length     = pwdata[CfgW-1:0];
        REG_COOLDOWN:      cfg_d.trigger_cooldown = pwdata[CfgW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MANUAL_ON:     prdata = ApbDataW'(cfg_q.manual_on);
      REG_AUTO_ENABLE:   prdata = ApbDataW'(cfg_q.auto_enable);
      REG_DARK_THRESH:   prdata = ApbDataW'(cfg_q.dark_limit);
      REG_FOYER_HOLD:    prdata = ApbDataW'(cfg_q.foyer_hold);
      REG_SECURITY_HOLD: prdata = ApbDataW'(cfg_q.security_hold);
      REG_PULSE_LENGTH:  prdata = ApbDataW'(cfg_q.pulse_length);
      REG_COOLDOWN:      prdata = ApbDataW'(cfg_q.trigger_cooldown);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_on        <= RstManualOn;
      cfg_q.auto_enable      <= RstAutoEnable;
      cfg_q.dark_limit       <= RstDarkThresh;
      cfg_q.foyer_hold       <= RstFoyerHold;
      cfg_q.security_hold    <= RstSecHold;
      cfg_q.pulse_length     <= RstPulseLen;
      cfg_q.trigger_cooldown <= RstCooldown;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/mlcc_tick.sv]
// ----------------------------------------------------------------------------
// mlcc_tick
// Per-tick decision logic and the saturating tick counters behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcc_tick #(
  parameter int COUNT_WIDTH = mlcc_pkg::CountWidth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mlcc_pkg::cfg_t cfg_i,
  input  wire logic           advance_i,
  input  wire mlcc_pkg::in_t  item_i,
  output mlcc_pkg::res_t      res_o
);
  import mlcc_pkg::*;

  localparam int CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == CntMax) ? CntMax : cnt_t'(c + 1'b1);
  endfunction

  // saturated age always counts as long past any limit
  function automatic logic reached(input cnt_t age, input logic [CfgW-1:0] limit);
    return (age == CntMax) || (CmpW'(age) >= CmpW'(limit));
  endfunction

  function automatic logic held(input cnt_t age, input logic [CfgW-1:0] limit);
    return (age != CntMax) && (CmpW'(age) < CmpW'(limit));
  endfunction

  logic              prior_mo_q;
  cnt_t              out_idle_q, out_idle_d;
  cnt_t              in_idle_q, in_idle_d;
  logic              pulse_on_q, pulse_on_d;
  cnt_t              pulse_cnt_q, pulse_cnt_d;
  cnt_t              gap_q, gap_d;
  logic [LightW-1:0] last_lights_q, lights;
  logic              first_done_q;

  logic auto_porch, auto_foyer, sec_auto, dark, start;
  cnt_t gap_inc, pulse_inc;

  assign auto_porch = cfg_i.auto_enable[LightPorch];
  assign auto_foyer = cfg_i.auto_enable[LightFoyer];
  assign sec_auto   = cfg_i.auto_enable[LightSecurity];

  assign dark = item_i.ambient_valid && (item_i.ambient_level <= cfg_i.dark_limit);

  always_comb begin
    out_idle_d = (sec_auto && item_i.motion_outside) ? '0 : sat_inc(out_idle_q);
    in_idle_d  = (auto_foyer && item_i.motion_inside) ? '0 : sat_inc(in_idle_q);
    gap_inc    = sat_inc(gap_q);
    pulse_inc  = pulse_on_q ? sat_inc(pulse_cnt_q) : pulse_cnt_q;

    // rising edge of outside motion, no pulse running, cooldown met
    start = sec_auto && item_i.motion_outside && !prior_mo_q && !pulse_on_q &&
            reached(gap_inc, cfg_i.trigger_cooldown);

    pulse_cnt_d = start ? '0 : pulse_inc;
    gap_d       = start ? '0 : gap_inc;
    pulse_on_d  = (pulse_on_q || start) && !reached(pulse_cnt_d, cfg_i.pulse_length) &&
                  sec_auto;

    lights[LightPorch]    = cfg_i.manual_on[LightPorch] || (auto_porch && dark);
    lights[LightFoyer]    = cfg_i.manual_on[LightFoyer] ||
                            (auto_foyer && held(in_idle_d, cfg_i.foyer_hold));
    lights[LightSecurity] = cfg_i.manual_on[LightSecurity] ||
                            (sec_auto && held(out_idle_d, cfg_i.security_hold));
  end

  always_comb begin
    res_o.porch_light       = lights[LightPorch];
    res_o.foyer_light       = lights[LightFoyer];
    res_o.security_light    = lights[LightSecurity];
    res_o.camera_trigger    = pulse_on_d;
    res_o.is_dark           = dark;
    res_o.light_change_mask = first_done_q ? (lights ^ last_lights_q) : '1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_mo_q    <= 1'b0;
      out_idle_q    <= CntMax;
      in_idle_q     <= CntMax;
      pulse_on_q    <= 1'b0;
      pulse_cnt_q   <= '0;
      gap_q         <= CntMax;
      last_lights_q <= '0;
      first_done_q  <= 1'b0;
    end else if (advance_i) begin
      prior_mo_q    <= item_i.motion_outside;
      out_idle_q    <= out_idle_d;
      in_idle_q     <= in_idle_d;
      pulse_on_q    <= pulse_on_d;
      pulse_cnt_q   <= pulse_cnt_d;
      gap_q         <= gap_d;
      last_lights_q <= lights;
      first_done_q  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[design/mlcc_checker.sv]
// ----------------------------------------------------------------------------
// mlcc_checker
// Port-level checks of the controller's handshake and change mask.
// ----------------------------------------------------------------------------
`default_nettype none

module mlcc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        porch_light,
  input wire logic                        foyer_light,
  input wire logic                        security_light,
  input wire logic                        camera_trigger,
  input wire logic                        is_dark,
  input wire logic [mlcc_pkg::LightW-1:0] light_change_mask
);
  import mlcc_pkg::*;

  logic              out_fire;
  logic              seen_q;
  logic [LightW-1:0] lights, last_q;

  assign out_fire = out_valid && out_ready;
  assign lights   = {security_light, foyer_light, porch_light};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_fire) begin
      seen_q <= 1'b1;
      last_q <= lights;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(lights) &&
      $stable(camera_trigger) && $stable(is_dark) && $stable(light_change_mask))
    else $error("result word changed while stalled");

  a_first_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !seen_q |-> light_change_mask == '1)
    else $error("first result word must flag all lights changed");

  a_mask_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q |-> light_change_mask == (lights ^ last_q))
    else $error("change mask does not match light transitions");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind motion_light_and_camera_controller_top mlcc_checker u_mlcc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_i.valid),
  .in_ready          (in_i.ready),
  .out_valid         (out_o.valid),
  .out_ready         (out_o.ready),
  .porch_light       (out_o.porch_light),
  .foyer_light       (out_o.foyer_light),
  .security_light    (out_o.security_light),
  .camera_trigger    (out_o.camera_trigger),
  .is_dark           (out_o.is_dark),
  .light_change_mask (out_o.light_change_mask)
);

`default_nettype wire
